/* src/l4dec_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the line-4 opcode decoder.
package l4dec_pkg;

    localparam int OpW = 12;

    // Instruction classes
    localparam logic [4:0] CLS_NEGX    = 5'd0;
    localparam logic [4:0] CLS_TST     = 5'd5;
    localparam logic [4:0] CLS_NBCD    = 5'd4;
    localparam logic [4:0] CLS_SWAP    = 5'd6;
    localparam logic [4:0] CLS_PEA     = 5'd7;
    localparam logic [4:0] CLS_TRAP    = 5'd8;
    localparam logic [4:0] CLS_LINK    = 5'd9;
    localparam logic [4:0] CLS_UNLK    = 5'd10;
    localparam logic [4:0] CLS_MOVEUSP = 5'd11;
    localparam logic [4:0] CLS_RESET   = 5'd12;
    localparam logic [4:0] CLS_NOP     = 5'd13;
    localparam logic [4:0] CLS_STOP    = 5'd14;
    localparam logic [4:0] CLS_RTE     = 5'd15;
    localparam logic [4:0] CLS_RTS     = 5'd16;
    localparam logic [4:0] CLS_TRAPV   = 5'd17;
    localparam logic [4:0] CLS_RTR     = 5'd18;
    localparam logic [4:0] CLS_EXT     = 5'd19;
    localparam logic [4:0] CLS_MOVEM   = 5'd20;
    localparam logic [4:0] CLS_JSR     = 5'd21;
    localparam logic [4:0] CLS_JMP     = 5'd22;
    localparam logic [4:0] CLS_MOVESR  = 5'd23;
    localparam logic [4:0] CLS_TAS     = 5'd24;
    localparam logic [4:0] CLS_ILLEGAL = 5'd25;
    localparam logic [4:0] CLS_CHK     = 5'd26;
    localparam logic [4:0] CLS_LEA     = 5'd27;

    // Operand sizes
    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_WORD = 2'd1;
    localparam logic [1:0] SZ_LONG = 2'd2;
    localparam logic [1:0] SZ_NONE = 2'd3;

    // Effective-address kinds
    localparam logic [3:0] KIND_DN     = 4'd0;
    localparam logic [3:0] KIND_AN     = 4'd1;
    localparam logic [3:0] KIND_PREDEC = 4'd4;
    localparam logic [3:0] KIND_IDX    = 4'd6;
    localparam logic [3:0] KIND_ABSW   = 4'd7;
    localparam logic [3:0] KIND_IMM    = 4'd11;
    localparam logic [3:0] KIND_NONE   = 4'd12;
    localparam logic [3:0] KIND_BAD    = 4'd13;

    // Legal EA kinds per addressing category, bit n = kind n
    localparam logic [11:0] M_DALT  = 12'h1FD;
    localparam logic [11:0] M_CTRL  = 12'h7E4;
    localparam logic [11:0] M_DATA  = 12'hFFD;
    localparam logic [11:0] M_MVM_W = 12'h1F4;
    localparam logic [11:0] M_MVM_R = 12'h7EC;

    typedef struct packed {
        logic       valid_res;
        logic [4:0] instr_class;
        logic [1:0] op_size;
        logic [3:0] ea_kind;
        logic [2:0] ea_reg;
        logic [2:0] other_reg;
        logic       ea_is_source;
        logic       needs_reglist;
        logic       reverse_reglist;
        logic [3:0] trap_vector;
        logic       needs_imm_word;
    } dec_t;

    localparam dec_t DEC_INVALID = '{
        valid_res: 1'b0, instr_class: 5'd0, op_size: 2'd0, ea_kind: KIND_NONE,
        ea_reg: 3'd0, other_reg: 3'd0, ea_is_source: 1'b0, needs_reglist: 1'b0,
        reverse_reglist: 1'b0, trap_vector: 4'd0, needs_imm_word: 1'b0
    };

endpackage

/* src/l4dec_decode.sv */
`timescale 1ns / 1ps
// Combinational decode of the low 12 bits of a line-4 opcode.
module l4dec_decode (
    input  logic [l4dec_pkg::OpW-1:0] opcode,
    output l4dec_pkg::dec_t           dec
);

    logic [2:0] rx, mx, my, ry;
    logic [3:0] kind;

    assign rx = opcode[11:9];
    assign mx = opcode[8:6];
    assign my = opcode[5:3];
    assign ry = opcode[2:0];

    // Mode 7 sub-codes above 4 are no address at all
    always_comb begin
        if (my != 3'd7) begin
            kind = {1'b0, my};
        end else if (ry <= 3'd4) begin
            kind = l4dec_pkg::KIND_ABSW + {1'b0, ry};
        end else begin
            kind = l4dec_pkg::KIND_BAD;
        end
    end

    // EA-checked instruction: invalid unless the kind is in the legal set
    function automatic l4dec_pkg::dec_t acc(input logic [4:0] cls, input logic [1:0] sz,
                                            input logic [11:0] mask, input logic [3:0] k,
                                            input logic [2:0] r);
        l4dec_pkg::dec_t d;
        d = l4dec_pkg::DEC_INVALID;
        if (k != l4dec_pkg::KIND_BAD && mask[k]) begin
            d.valid_res   = 1'b1;
            d.instr_class = cls;
            d.op_size     = sz;
            d.ea_kind     = k;
            d.ea_reg      = (k <= l4dec_pkg::KIND_IDX) ? r : 3'd0;
        end
        return d;
    endfunction

    function automatic l4dec_pkg::dec_t fixed(input logic [4:0] cls, input logic [1:0] sz,
                                              input logic [3:0] k, input logic [2:0] r);
        l4dec_pkg::dec_t d;
        d             = l4dec_pkg::DEC_INVALID;
        d.valid_res   = 1'b1;
        d.instr_class = cls;
        d.op_size     = sz;
        d.ea_kind     = k;
        d.ea_reg      = r;
        return d;
    endfunction

    always_comb begin
        dec = l4dec_pkg::DEC_INVALID;
        if (mx <= 3'd2 && rx <= 3'd3) begin
            // NEGX, CLR, NEG, NOT share the layout; class is rx
            dec = acc({2'b00, rx}, mx[1:0], l4dec_pkg::M_DALT, kind, ry);
        end else if (mx <= 3'd2 && rx == 3'd5) begin
            dec = acc(l4dec_pkg::CLS_TST, mx[1:0], l4dec_pkg::M_DALT, kind, ry);
        end else begin
            unique case (mx)
                3'd0: begin
                    if (rx == 3'd4) begin
                        dec = acc(l4dec_pkg::CLS_NBCD, l4dec_pkg::SZ_BYTE, l4dec_pkg::M_DALT,
                                  kind, ry);
                    end
                end
                3'd1: begin
                    if (rx == 3'd4) begin
                        if (my == 3'd0) begin
                            dec = fixed(l4dec_pkg::CLS_SWAP, l4dec_pkg::SZ_WORD,
                                        l4dec_pkg::KIND_DN, ry);
                        end else begin
                            dec = acc(l4dec_pkg::CLS_PEA, l4dec_pkg::SZ_LONG, l4dec_pkg::M_CTRL,
                                      kind, ry);
                            dec.ea_is_source = dec.valid_res;
                        end
                    end else if (rx == 3'd7) begin
                        unique case (my)
                            3'd0, 3'd1: begin
                                dec = fixed(l4dec_pkg::CLS_TRAP, l4dec_pkg::SZ_NONE,
                                            l4dec_pkg::KIND_NONE, 3'd0);
                                dec.trap_vector = opcode[3:0];
                            end
                            3'd2: begin
                                dec = fixed(l4dec_pkg::CLS_LINK, l4dec_pkg::SZ_WORD,
                                            l4dec_pkg::KIND_AN, ry);
                                dec.needs_imm_word = 1'b1;
                            end
                            3'd3: begin
                                dec = fixed(l4dec_pkg::CLS_UNLK, l4dec_pkg::SZ_NONE,
                                            l4dec_pkg::KIND_AN, ry);
                            end
                            3'd4: begin
                                dec = fixed(l4dec_pkg::CLS_MOVEUSP, l4dec_pkg::SZ_LONG,
                                            l4dec_pkg::KIND_AN, ry);
                                dec.ea_is_source = 1'b1;
                            end
                            3'd5: begin
                                dec = fixed(l4dec_pkg::CLS_MOVEUSP, l4dec_pkg::SZ_LONG,
                                            l4dec_pkg::KIND_AN, ry);
                            end
                            3'd6: begin
                                // free slot between RTE and RTS stays invalid
                                if (ry < 3'd4) begin
                                    dec = fixed(l4dec_pkg::CLS_RESET + {2'b00, ry},
                                                l4dec_pkg::SZ_NONE, l4dec_pkg::KIND_NONE, 3'd0);
                                    dec.needs_imm_word = (dec.instr_class == l4dec_pkg::CLS_STOP);
                                end else if (ry != 3'd4) begin
                                    dec = fixed(l4dec_pkg::CLS_RTS + {2'b00, ry} - 5'd5,
                                                l4dec_pkg::SZ_NONE, l4dec_pkg::KIND_NONE, 3'd0);
                                end
                            end
                            3'd7: begin
                                dec = l4dec_pkg::DEC_INVALID;
                            end
                        endcase
                    end
                end
                3'd2, 3'd3: begin
                    if (rx == 3'd4) begin
                        if (my == 3'd0) begin
                            dec = fixed(l4dec_pkg::CLS_EXT, 2'(mx - 3'd1), l4dec_pkg::KIND_DN, ry);
                        end else begin
                            dec = acc(l4dec_pkg::CLS_MOVEM, 2'(mx - 3'd1), l4dec_pkg::M_MVM_W,
                                      kind, ry);
                            dec.needs_reglist   = dec.valid_res;
                            dec.reverse_reglist = dec.valid_res && (my == 3'd4);
                        end
                    end else if (rx == 3'd6) begin
                        dec = acc(l4dec_pkg::CLS_MOVEM, 2'(mx - 3'd1), l4dec_pkg::M_MVM_R,
                                  kind, ry);
                        dec.needs_reglist = dec.valid_res;
                        dec.ea_is_source  = dec.valid_res;
                    end else if (rx == 3'd7) begin
                        dec = acc((mx == 3'd2) ? l4dec_pkg::CLS_JSR : l4dec_pkg::CLS_JMP,
                                  l4dec_pkg::SZ_NONE, l4dec_pkg::M_CTRL, kind, ry);
                    end else if (mx == 3'd3) begin
                        if (rx == 3'd0) begin
                            dec = acc(l4dec_pkg::CLS_MOVESR, l4dec_pkg::SZ_WORD,
                                      l4dec_pkg::M_DALT, kind, ry);
                        end else if (rx == 3'd2 || rx == 3'd3) begin
                            dec = acc(l4dec_pkg::CLS_MOVESR, l4dec_pkg::SZ_WORD,
                                      l4dec_pkg::M_DATA, kind, ry);
                            dec.ea_is_source = dec.valid_res;
                            dec.other_reg    = dec.valid_res ? rx : 3'd0;
                        end else if (rx == 3'd5) begin
                            // TAS with an immediate operand is the ILLEGAL slot
                            if (kind == l4dec_pkg::KIND_IMM) begin
                                dec = fixed(l4dec_pkg::CLS_ILLEGAL, l4dec_pkg::SZ_NONE,
                                            l4dec_pkg::KIND_NONE, 3'd0);
                            end else begin
                                dec = acc(l4dec_pkg::CLS_TAS, l4dec_pkg::SZ_BYTE,
                                          l4dec_pkg::M_DALT, kind, ry);
                            end
                        end
                    end
                end
                3'd4, 3'd5: begin
                    dec = l4dec_pkg::DEC_INVALID;
                end
                3'd6: begin
                    dec = acc(l4dec_pkg::CLS_CHK, l4dec_pkg::SZ_WORD, l4dec_pkg::M_DATA,
                              kind, ry);
                    dec.ea_is_source = dec.valid_res;
                    dec.other_reg    = dec.valid_res ? rx : 3'd0;
                end
                3'd7: begin
                    dec = acc(l4dec_pkg::CLS_LEA, l4dec_pkg::SZ_LONG, l4dec_pkg::M_CTRL,
                              kind, ry);
                    dec.ea_is_source = dec.valid_res;
                    dec.other_reg    = dec.valid_res ? rx : 3'd0;
                end
            endcase
        end
    end

endmodule

/* src/line4_opcode_decoder_unit.sv */
`timescale 1ns / 1ps
// Line-4 opcode decoder: takes one opcode request per clock and returns one decoded
// result for each. The opcode is registered on acceptance, decoded by table logic and
// registered again in the result register, which drives the m_ side; with m_ready held
// high the unit sustains one request every cycle. The two registers let a new request
// in while a finished result still waits on m_ready.
module line4_opcode_decoder_unit (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [l4dec_pkg::OpW-1:0] s_opcode_low,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_valid_res,
    output logic [4:0]                m_instr_class,
    output logic [1:0]                m_op_size,
    output logic [3:0]                m_ea_kind,
    output logic [2:0]                m_ea_reg,
    output logic [2:0]                m_other_reg,
    output logic                      m_ea_is_source,
    output logic                      m_needs_reglist,
    output logic                      m_reverse_reglist,
    output logic [3:0]                m_trap_vector,
    output logic                      m_needs_imm_word
);

    logic                      in_vld_reg;
    logic [l4dec_pkg::OpW-1:0] op_reg;
    logic                      out_vld_reg;
    l4dec_pkg::dec_t           res_reg;
    l4dec_pkg::dec_t           dec_next;
    logic                      out_free;
    logic                      adv;

    l4dec_decode u_decode (
        .opcode (op_reg),
        .dec    (dec_next)
    );

    assign out_free = !out_vld_reg || m_ready;
    assign adv      = in_vld_reg && out_free;
    assign s_ready  = !in_vld_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            if (out_free) begin
                out_vld_reg <= in_vld_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg <= s_opcode_low;
        end
        if (adv) begin
            res_reg <= dec_next;
        end
    end

    assign m_valid           = out_vld_reg;
    assign m_valid_res       = res_reg.valid_res;
    assign m_instr_class     = res_reg.instr_class;
    assign m_op_size         = res_reg.op_size;
    assign m_ea_kind         = res_reg.ea_kind;
    assign m_ea_reg          = res_reg.ea_reg;
    assign m_other_reg       = res_reg.other_reg;
    assign m_ea_is_source    = res_reg.ea_is_source;
    assign m_needs_reglist   = res_reg.needs_reglist;
    assign m_reverse_reglist = res_reg.reverse_reglist;
    assign m_trap_vector     = res_reg.trap_vector;
    assign m_needs_imm_word  = res_reg.needs_imm_word;

    // An accepted request always occupies the input stage next cycle
    a_take_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> in_vld_reg)
        else $error("accepted request lost from input stage");

    a_invalid_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_valid_res |->
            m_ea_kind == l4dec_pkg::KIND_NONE && m_instr_class == 5'd0
            && !m_ea_is_source && !m_needs_reglist && !m_needs_imm_word)
        else $error("invalid encoding carries stray fields");

    a_reglist_movem: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_needs_reglist |-> m_instr_class == l4dec_pkg::CLS_MOVEM)
        else $error("register list flagged outside MOVEM");

    a_reverse_predec: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_reverse_reglist |->
            m_needs_reglist && m_ea_kind == l4dec_pkg::KIND_PREDEC)
        else $error("reversed list without predecrement MOVEM");

    a_imm_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_needs_imm_word |->
            m_instr_class == l4dec_pkg::CLS_LINK || m_instr_class == l4dec_pkg::CLS_STOP)
        else $error("immediate word flagged outside LINK/STOP");

endmodule

/* test/line4_opcode_decoder_unit_tb.sv */
`timescale 1ns / 1ps
// Testbench for the line-4 opcode decoder: directed table, random opcodes, scoreboard.
module tb;

    localparam int RANDOM_OPS     = 1750;
    localparam int DRAIN_CYCLES   = 10;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int MAX_REPORTS    = 10;

    localparam l4dec_pkg::dec_t NEGX_B_D0 = '{valid_res: 1'b1,
        instr_class: l4dec_pkg::CLS_NEGX, op_size: l4dec_pkg::SZ_BYTE,
        ea_kind: l4dec_pkg::KIND_DN, default: '0};
    localparam l4dec_pkg::dec_t NOP_DEC = '{valid_res: 1'b1,
        instr_class: l4dec_pkg::CLS_NOP, op_size: l4dec_pkg::SZ_NONE,
        ea_kind: l4dec_pkg::KIND_NONE, default: '0};
    localparam l4dec_pkg::dec_t TRAP15_DEC = '{valid_res: 1'b1,
        instr_class: l4dec_pkg::CLS_TRAP, op_size: l4dec_pkg::SZ_NONE,
        ea_kind: l4dec_pkg::KIND_NONE, trap_vector: 4'hF, default: '0};
    localparam l4dec_pkg::dec_t ILLEGAL_DEC = '{valid_res: 1'b1,
        instr_class: l4dec_pkg::CLS_ILLEGAL, op_size: l4dec_pkg::SZ_NONE,
        ea_kind: l4dec_pkg::KIND_NONE, default: '0};
    localparam l4dec_pkg::dec_t INV = l4dec_pkg::DEC_INVALID;

    typedef struct packed {
        logic [11:0]     op;
        logic            typed;   // use the result given here rather than the predictor's
        l4dec_pkg::dec_t want;
    } stim_row_t;

    localparam int N_DIR = 34;
    localparam stim_row_t DIR_ROWS [N_DIR] = '{
        '{12'h000, 1'b1, NEGX_B_D0},     // NEGX.B D0, all zero
        '{12'hFFF, 1'b1, INV},           // all ones: LEA with a spare mode-7 sub-code
        '{12'h259, 1'b0, INV},           // CLR.W (A1)+
        '{12'h4B9, 1'b0, INV},           // NEG.L abs.L
        '{12'h627, 1'b0, INV},           // NOT.B -(A7)
        '{12'h82A, 1'b0, INV},           // NBCD d16(A2)
        '{12'hA73, 1'b0, INV},           // TST.W index
        '{12'h845, 1'b0, INV},           // SWAP D5
        '{12'h87A, 1'b0, INV},           // PEA d16(PC)
        '{12'hE4F, 1'b1, TRAP15_DEC},    // TRAP #15
        '{12'hE56, 1'b0, INV},           // LINK A6
        '{12'hE5E, 1'b0, INV},           // UNLK A6
        '{12'hE63, 1'b0, INV},           // MOVE A3,USP
        '{12'hE6B, 1'b0, INV},           // MOVE USP,A3
        '{12'hE70, 1'b0, INV},           // RESET
        '{12'hE71, 1'b1, NOP_DEC},       // NOP
        '{12'hE72, 1'b0, INV},           // STOP
        '{12'hE73, 1'b0, INV},           // RTE
        '{12'hE74, 1'b1, INV},           // free slot
        '{12'hE75, 1'b0, INV},           // RTS
        '{12'hE76, 1'b0, INV},           // TRAPV
        '{12'hE77, 1'b0, INV},           // RTR
        '{12'h8C7, 1'b0, INV},           // EXT.L D7
        '{12'h8A7, 1'b0, INV},           // MOVEM.W list,-(A7): reversed list
        '{12'hCD8, 1'b0, INV},           // MOVEM.L (A0)+,list
        '{12'hE90, 1'b0, INV},           // JSR (A0)
        '{12'hEF8, 1'b0, INV},           // JMP abs.W
        '{12'h4FC, 1'b0, INV},           // MOVE #imm,CCR
        '{12'h2C0, 1'b1, INV},           // MOVE from CCR, later family
        '{12'hAFC, 1'b1, ILLEGAL_DEC},   // TAS slot with immediate
        '{12'hAC0, 1'b0, INV},           // TAS D0
        '{12'hFBC, 1'b0, INV},           // CHK.W #imm,D7
        '{12'h1D0, 1'b0, INV},           // LEA (A0),A0
        '{12'h100, 1'b1, INV}            // size/mode 4, later family
    };

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [11:0] s_opcode_low;
    logic        m_valid;
    logic        m_ready;
    logic        m_valid_res;
    logic [4:0]  m_instr_class;
    logic [1:0]  m_op_size;
    logic [3:0]  m_ea_kind;
    logic [2:0]  m_ea_reg;
    logic [2:0]  m_other_reg;
    logic        m_ea_is_source;
    logic        m_needs_reglist;
    logic        m_reverse_reglist;
    logic [3:0]  m_trap_vector;
    logic        m_needs_imm_word;

    l4dec_pkg::dec_t decoded_q [$];
    l4dec_pkg::dec_t pending_dec;      // travels with the request on s_opcode_low
    int              fault_count = 0;
    int              quiet_cycles = 0;

    line4_opcode_decoder_unit dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_opcode_low      (s_opcode_low),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_valid_res       (m_valid_res),
        .m_instr_class     (m_instr_class),
        .m_op_size         (m_op_size),
        .m_ea_kind         (m_ea_kind),
        .m_ea_reg          (m_ea_reg),
        .m_other_reg       (m_other_reg),
        .m_ea_is_source    (m_ea_is_source),
        .m_needs_reglist   (m_needs_reglist),
        .m_reverse_reglist (m_reverse_reglist),
        .m_trap_vector     (m_trap_vector),
        .m_needs_imm_word  (m_needs_imm_word)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    function automatic bit ea_ok(input logic [11:0] mask, input logic [3:0] kind);
        return (kind <= l4dec_pkg::KIND_IMM) && mask[kind];
    endfunction

    function automatic l4dec_pkg::dec_t ea_result(input logic [4:0] cls,
                                                  input logic [1:0] size,
                                                  input logic [3:0] kind,
                                                  input logic [2:0] ry);
        l4dec_pkg::dec_t d;
        d = l4dec_pkg::DEC_INVALID;
        d.valid_res   = 1'b1;
        d.instr_class = cls;
        d.op_size     = size;
        d.ea_kind     = kind;
        d.ea_reg      = (kind <= l4dec_pkg::KIND_IDX) ? ry : 3'd0;
        return d;
    endfunction

    function automatic l4dec_pkg::dec_t decode_line4(input logic [11:0] op);
        logic [2:0]      rx;
        logic [2:0]      mx;
        logic [2:0]      my;
        logic [2:0]      ry;
        logic [3:0]      k;
        logic [1:0]      msize;
        l4dec_pkg::dec_t d;
        rx = op[11:9];
        mx = op[8:6];
        my = op[5:3];
        ry = op[2:0];
        k = (my != 3'd7) ? {1'b0, my}
          : (ry <= 3'd4) ? l4dec_pkg::KIND_ABSW + ry : l4dec_pkg::KIND_BAD;
        msize = (mx == 3'd2) ? l4dec_pkg::SZ_WORD : l4dec_pkg::SZ_LONG;
        d = l4dec_pkg::DEC_INVALID;
        if (mx <= 3'd2 && (rx <= 3'd3 || rx == 3'd5)) begin
            // NEGX, CLR, NEG, NOT by rx, or TST
            if (ea_ok(l4dec_pkg::M_DALT, k))
                d = ea_result((rx == 3'd5) ? l4dec_pkg::CLS_TST
                                           : l4dec_pkg::CLS_NEGX + 5'(rx), mx[1:0], k, ry);
        end else begin
            case (mx)
                3'd0: begin
                    if (rx == 3'd4 && ea_ok(l4dec_pkg::M_DALT, k))
                        d = ea_result(l4dec_pkg::CLS_NBCD, l4dec_pkg::SZ_BYTE, k, ry);
                end
                3'd1: begin
                    if (rx == 3'd4) begin
                        if (my == 3'd0) begin
                            d = ea_result(l4dec_pkg::CLS_SWAP, l4dec_pkg::SZ_WORD,
                                          l4dec_pkg::KIND_DN, ry);
                        end else if (ea_ok(l4dec_pkg::M_CTRL, k)) begin
                            d = ea_result(l4dec_pkg::CLS_PEA, l4dec_pkg::SZ_LONG, k, ry);
                            d.ea_is_source = 1'b1;
                        end
                    end else if (rx == 3'd7) begin
                        case (my)
                            3'd0, 3'd1: begin
                                d = ea_result(l4dec_pkg::CLS_TRAP, l4dec_pkg::SZ_NONE,
                                              l4dec_pkg::KIND_NONE, ry);
                                d.trap_vector = op[3:0];
                            end
                            3'd2: begin
                                d = ea_result(l4dec_pkg::CLS_LINK, l4dec_pkg::SZ_WORD,
                                              l4dec_pkg::KIND_AN, ry);
                                d.needs_imm_word = 1'b1;
                            end
                            3'd3: d = ea_result(l4dec_pkg::CLS_UNLK, l4dec_pkg::SZ_NONE,
                                                l4dec_pkg::KIND_AN, ry);
                            3'd4: begin
                                d = ea_result(l4dec_pkg::CLS_MOVEUSP, l4dec_pkg::SZ_LONG,
                                              l4dec_pkg::KIND_AN, ry);
                                d.ea_is_source = 1'b1;
                            end
                            3'd5: d = ea_result(l4dec_pkg::CLS_MOVEUSP, l4dec_pkg::SZ_LONG,
                                                l4dec_pkg::KIND_AN, ry);
                            3'd6: begin
                                case (ry)
                                    3'd0: d = ea_result(l4dec_pkg::CLS_RESET,
                                                        l4dec_pkg::SZ_NONE,
                                                        l4dec_pkg::KIND_NONE, ry);
                                    3'd1: d = ea_result(l4dec_pkg::CLS_NOP,
                                                        l4dec_pkg::SZ_NONE,
                                                        l4dec_pkg::KIND_NONE, ry);
                                    3'd2: begin
                                        d = ea_result(l4dec_pkg::CLS_STOP,
                                                      l4dec_pkg::SZ_NONE,
                                                      l4dec_pkg::KIND_NONE, ry);
                                        d.needs_imm_word = 1'b1;
                                    end
                                    3'd3: d = ea_result(l4dec_pkg::CLS_RTE,
                                                        l4dec_pkg::SZ_NONE,
                                                        l4dec_pkg::KIND_NONE, ry);
                                    3'd5: d = ea_result(l4dec_pkg::CLS_RTS,
                                                        l4dec_pkg::SZ_NONE,
                                                        l4dec_pkg::KIND_NONE, ry);
                                    3'd6: d = ea_result(l4dec_pkg::CLS_TRAPV,
                                                        l4dec_pkg::SZ_NONE,
                                                        l4dec_pkg::KIND_NONE, ry);
                                    3'd7: d = ea_result(l4dec_pkg::CLS_RTR,
                                                        l4dec_pkg::SZ_NONE,
                                                        l4dec_pkg::KIND_NONE, ry);
                                    default: ;  // free slot stays invalid
                                endcase
                            end
                            default: ;
                        endcase
                    end
                end
                3'd2, 3'd3: begin
                    if (rx == 3'd4) begin
                        if (my == 3'd0) begin
                            d = ea_result(l4dec_pkg::CLS_EXT, msize, l4dec_pkg::KIND_DN, ry);
                        end else if (ea_ok(l4dec_pkg::M_MVM_W, k)) begin
                            d = ea_result(l4dec_pkg::CLS_MOVEM, msize, k, ry);
                            d.needs_reglist   = 1'b1;
                            d.reverse_reglist = (k == l4dec_pkg::KIND_PREDEC);
                        end
                    end else if (rx == 3'd6) begin
                        if (ea_ok(l4dec_pkg::M_MVM_R, k)) begin
                            d = ea_result(l4dec_pkg::CLS_MOVEM, msize, k, ry);
                            d.needs_reglist = 1'b1;
                            d.ea_is_source  = 1'b1;
                        end
                    end else if (rx == 3'd7) begin
                        if (ea_ok(l4dec_pkg::M_CTRL, k))
                            d = ea_result((mx == 3'd2) ? l4dec_pkg::CLS_JSR
                                                       : l4dec_pkg::CLS_JMP,
                                          l4dec_pkg::SZ_NONE, k, ry);
                    end else if (mx == 3'd3) begin
                        if (rx == 3'd0) begin
                            if (ea_ok(l4dec_pkg::M_DALT, k))
                                d = ea_result(l4dec_pkg::CLS_MOVESR, l4dec_pkg::SZ_WORD,
                                              k, ry);
                        end else if (rx == 3'd2 || rx == 3'd3) begin
                            if (ea_ok(l4dec_pkg::M_DATA, k)) begin
                                d = ea_result(l4dec_pkg::CLS_MOVESR, l4dec_pkg::SZ_WORD,
                                              k, ry);
                                d.ea_is_source = 1'b1;
                                d.other_reg    = rx;
                            end
                        end else if (rx == 3'd5) begin
                            if (k == l4dec_pkg::KIND_IMM)
                                d = ea_result(l4dec_pkg::CLS_ILLEGAL, l4dec_pkg::SZ_NONE,
                                              l4dec_pkg::KIND_NONE, ry);
                            else if (ea_ok(l4dec_pkg::M_DALT, k))
                                d = ea_result(l4dec_pkg::CLS_TAS, l4dec_pkg::SZ_BYTE, k, ry);
                        end
                    end
                end
                3'd6: begin
                    if (ea_ok(l4dec_pkg::M_DATA, k)) begin
                        d = ea_result(l4dec_pkg::CLS_CHK, l4dec_pkg::SZ_WORD, k, ry);
                        d.ea_is_source = 1'b1;
                        d.other_reg    = rx;
                    end
                end
                3'd7: begin
                    if (ea_ok(l4dec_pkg::M_CTRL, k)) begin
                        d = ea_result(l4dec_pkg::CLS_LEA, l4dec_pkg::SZ_LONG, k, ry);
                        d.ea_is_source = 1'b1;
                        d.other_reg    = rx;
                    end
                end
                default: ;  // size/mode 4 and 5
            endcase
        end
        return d;
    endfunction

    function automatic string dec_str(input l4dec_pkg::dec_t d);
        return $sformatf("v=%0d cls=%0d sz=%0d kind=%0d reg=%0d oreg=%0d src=%0d %s",
                         d.valid_res, d.instr_class, d.op_size, d.ea_kind, d.ea_reg,
                         d.other_reg, d.ea_is_source,
                         $sformatf("rl=%0d rev=%0d vec=%0d imm=%0d", d.needs_reglist,
                                   d.reverse_reglist, d.trap_vector, d.needs_imm_word));
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    function automatic logic [11:0] pick_opcode();
        int         r;
        logic [2:0] mx;
        logic [2:0] my;
        logic [2:0] ry;
        r = $urandom_range(0, 9);
        if (r < 4) return 12'($urandom_range(0, 4095));
        // the control block at rx 7, mx 1
        if (r < 6) return 12'hE40 | 12'($urandom_range(0, 63));
        case ($urandom_range(0, 5))
            0: mx = 3'd0;
            1: mx = 3'd1;
            2: mx = 3'd2;
            3: mx = 3'd3;
            4: mx = 3'd6;
            default: mx = 3'd7;
        endcase
        my = 3'($urandom_range(0, 7));
        // keep mode 7 mostly on real addresses
        ry = (my == 3'd7 && $urandom_range(0, 3) != 0) ? 3'($urandom_range(0, 4))
                                                       : 3'($urandom_range(0, 7));
        return {3'($urandom_range(0, 7)), mx, my, ry};
    endfunction

    task automatic send_opcode(input logic [11:0] op, input l4dec_pkg::dec_t want,
                               input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_opcode_low <= op;
        pending_dec  <= want;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic note_fault(input string msg);
        fault_count++;
        if (fault_count <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
    endtask

    initial begin : stimulus
        int          n;
        bit          calm;
        logic [11:0] op;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_opcode_low = '0;
        pending_dec  = l4dec_pkg::DEC_INVALID;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        for (n = 0; n < N_DIR; n++)
            send_opcode(DIR_ROWS[n].op,
                        DIR_ROWS[n].typed ? DIR_ROWS[n].want : decode_line4(DIR_ROWS[n].op),
                        pick_gap());
        calm = 1'b0;
        for (n = 0; n < RANDOM_OPS; n++) begin
            if (n % 64 == 0) calm = ($urandom_range(0, 3) == 0);
            op = pick_opcode();
            send_opcode(op, decode_line4(op), calm ? 0 : pick_gap());
        end
        s_valid <= 1'b0;
        // let the scoreboard log the last request before watching the queue
        @(posedge aclk);
        while (decoded_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fault_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin : result_sink
        int run;
        int stall;
        m_ready = 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            run = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 8);
            m_ready <= 1'b1;
            repeat (run) @(posedge aclk);
            stall = pick_gap();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin : scoreboard
        l4dec_pkg::dec_t got;
        l4dec_pkg::dec_t want;
        if (aresetn) begin
            if (s_valid && s_ready) decoded_q.push_back(pending_dec);
            if (m_valid && m_ready) begin
                got = {m_valid_res, m_instr_class, m_op_size, m_ea_kind, m_ea_reg,
                       m_other_reg, m_ea_is_source, m_needs_reglist, m_reverse_reglist,
                       m_trap_vector, m_needs_imm_word};
                if (decoded_q.size() == 0) begin
                    note_fault({"result with no request pending: ", dec_str(got)});
                end else begin
                    want = decoded_q.pop_front();
                    if (got !== want)
                        note_fault({"mismatch\n  exp ", dec_str(want), "\n  got ", dec_str(got)});
                end
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

endmodule
